// ----- sv/gmc_pkg.sv -----
// shared constants, types and command/status structs of the min cut engine
`timescale 1ns / 1ps
package gmc_pkg;
    localparam int MAX_NODES   = 64;
    localparam int IDX_W       = $clog2(MAX_NODES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int CFG_W       = 7;
    localparam int WEIGHT_BITS = 24;
    localparam int WM_W        = 32;
    localparam int KEY_W       = 40;
    localparam int ADDR_W      = 2 * IDX_W;
    localparam logic [CFG_W-1:0] NODE_COUNT_RST = CFG_W'(MAX_NODES);

    typedef enum logic [4:0] {
        OP_IDLE, OP_INIT, OP_GINIT, OP_PH_START, OP_PAIR, OP_PAIR_RD, OP_PAIR_WT,
        OP_KCLR, OP_PICK, OP_PICK_END, OP_UPD, OP_CMP, OP_G_RDT, OP_G_RDS, OP_G_LAT,
        OP_SIDE, OP_M_CHK, OP_M_RD1, OP_M_RD2, OP_M_WR1, OP_M_WR2, OP_DEL, OP_RELAB,
        OP_OUT
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE, S_INIT, S_GINIT, S_PH_START, S_PAIR, S_PAIR_RD, S_PAIR_WT,
        S_KCLR, S_PICK, S_PICK_END, S_UPD, S_CMP, S_G_RDT, S_G_RDS, S_G_LAT,
        S_SIDE, S_M_CHK, S_M_RD1, S_M_RD2, S_M_WR1, S_M_WR2, S_DEL, S_RELAB,
        S_OUT
    } t_state;

    typedef struct packed {
        t_op  op;
        logic idx_clr;
        logic idx_inc;
    } t_cmd;

    typedef struct packed {
        logic             load_last;
        logic             idx_end;
        logic             skip;
        logic             live_one;
        logic             live_two;
        logic             iter_done;
        logic             out_space;
        logic             improved;
        logic [CNT_W-1:0] n;
    } t_stat;
endpackage

// ----- sv/gmc_if.sv -----
// channel interfaces: matrix entry input, per-node result output, node count write
`timescale 1ns / 1ps
interface gmc_in_if;
    import gmc_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [IDX_W-1:0]       row;
    logic [IDX_W-1:0]       col;
    logic [WEIGHT_BITS-1:0] weight;
    logic                   last_entry;
    modport source (output valid, row, col, weight, last_entry, input ready);
    modport sink   (input valid, row, col, weight, last_entry, output ready);
endinterface

interface gmc_out_if;
    import gmc_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] node;
    logic             in_cut_side;
    logic [KEY_W-1:0] cut_value;
    logic             last_node;
    modport source (output valid, node, in_cut_side, cut_value, last_node, input ready);
    modport sink   (input valid, node, in_cut_side, cut_value, last_node, output ready);
endinterface

interface gmc_cfg_if;
    import gmc_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- sv/gmc_ctrl.sv -----
// controller state machine sequencing load, search phases, merges and result output
`timescale 1ns / 1ps
module gmc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gmc_pkg::t_stat i_st,
    output gmc_pkg::t_cmd  o_cmd
);
    import gmc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_st.load_last) n_state = S_INIT;
            S_INIT:      n_state = S_GINIT;
            S_GINIT:     if (i_st.idx_end) n_state = S_PH_START;
            S_PH_START: begin
                priority if (i_st.live_one) n_state = S_OUT;
                else if (i_st.live_two)     n_state = S_PAIR;
                else                        n_state = S_KCLR;
            end
            S_PAIR:      if (i_st.idx_end) n_state = S_PAIR_RD;
            S_PAIR_RD:   n_state = S_PAIR_WT;
            S_PAIR_WT:   n_state = S_CMP;
            S_KCLR:      if (i_st.idx_end) n_state = S_PICK;
            S_PICK:      if (i_st.idx_end) n_state = S_PICK_END;
            S_PICK_END:  n_state = S_UPD;
            S_UPD: begin
                if (i_st.idx_end) n_state = i_st.iter_done ? S_CMP : S_PICK;
            end
            S_CMP:       n_state = S_G_RDT;
            S_G_RDT:     n_state = S_G_RDS;
            S_G_RDS:     n_state = S_G_LAT;
            S_G_LAT:     n_state = i_st.improved ? S_SIDE : S_M_CHK;
            S_SIDE:      if (i_st.idx_end) n_state = S_M_CHK;
            S_M_CHK: begin
                priority if (i_st.idx_end) n_state = S_DEL;
                else if (!i_st.skip)       n_state = S_M_RD1;
            end
            S_M_RD1:     n_state = S_M_RD2;
            S_M_RD2:     n_state = S_M_WR1;
            S_M_WR1:     n_state = S_M_WR2;
            S_M_WR2:     n_state = S_M_CHK;
            S_DEL:       n_state = S_RELAB;
            S_RELAB:     if (i_st.idx_end) n_state = S_PH_START;
            S_OUT:       if (i_st.idx_end) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.idx_inc = 1'b0;
        // the per-vertex merge loop keeps its index across its own states
        o_cmd.idx_clr = (n_state != r_state) && (r_state != S_M_WR2)
                        && (n_state != S_M_RD1) && (n_state != S_M_RD2)
                        && (n_state != S_M_WR1) && (n_state != S_M_WR2);
        unique case (r_state)
            S_IDLE:     o_cmd.op = OP_IDLE;
            S_INIT:     o_cmd.op = OP_INIT;
            S_GINIT:    o_cmd.op = OP_GINIT;
            S_PH_START: o_cmd.op = OP_PH_START;
            S_PAIR:     o_cmd.op = OP_PAIR;
            S_PAIR_RD:  o_cmd.op = OP_PAIR_RD;
            S_PAIR_WT:  o_cmd.op = OP_PAIR_WT;
            S_KCLR:     o_cmd.op = OP_KCLR;
            S_PICK:     o_cmd.op = OP_PICK;
            S_PICK_END: o_cmd.op = OP_PICK_END;
            S_UPD:      o_cmd.op = OP_UPD;
            S_CMP:      o_cmd.op = OP_CMP;
            S_G_RDT:    o_cmd.op = OP_G_RDT;
            S_G_RDS:    o_cmd.op = OP_G_RDS;
            S_G_LAT:    o_cmd.op = OP_G_LAT;
            S_SIDE:     o_cmd.op = OP_SIDE;
            S_M_CHK:    o_cmd.op = OP_M_CHK;
            S_M_RD1:    o_cmd.op = OP_M_RD1;
            S_M_RD2:    o_cmd.op = OP_M_RD2;
            S_M_WR1:    o_cmd.op = OP_M_WR1;
            S_M_WR2:    o_cmd.op = OP_M_WR2;
            S_DEL:      o_cmd.op = OP_DEL;
            S_RELAB:    o_cmd.op = OP_RELAB;
            S_OUT:      o_cmd.op = OP_OUT;
            default:    o_cmd.op = OP_IDLE;
        endcase
        unique case (r_state)
            S_GINIT, S_PAIR, S_KCLR, S_PICK, S_UPD, S_SIDE, S_RELAB:
                o_cmd.idx_inc = !i_st.idx_end;
            S_M_CHK:  o_cmd.idx_inc = !i_st.idx_end && i_st.skip;
            S_M_WR2:  o_cmd.idx_inc = 1'b1;
            S_OUT:    o_cmd.idx_inc = !i_st.idx_end && i_st.out_space;
            default:  o_cmd.idx_inc = 1'b0;
        endcase
    end
endmodule

// ----- sv/gmc_dp.sv -----
// datapath: weight, key and group memories, flags, sweep index, result register
`timescale 1ns / 1ps
module gmc_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gmc_pkg::t_cmd  i_cmd,
    output gmc_pkg::t_stat o_st,
    gmc_in_if.sink         i_in,
    gmc_out_if.source      o_out,
    gmc_cfg_if.sink        i_cfg
);
    import gmc_pkg::*;

    logic [WM_W-1:0]  r_wmem [MAX_NODES*MAX_NODES];
    logic [KEY_W-1:0] r_kmem [MAX_NODES];
    logic [IDX_W-1:0] r_gmem [MAX_NODES];

    logic [WM_W-1:0]  r_rw;
    logic [KEY_W-1:0] r_rk;
    logic [IDX_W-1:0] r_rg;

    logic [CFG_W-1:0]     r_cfg;
    logic [CNT_W-1:0]     r_n, r_idx, r_live, r_iter, n_clamp;
    logic [IDX_W-1:0]     r_idx_d, r_v, r_s0, r_s1, r_a, r_b, r_gt, r_gs;
    logic                 r_pend, r_elig, r_imp, r_ov;
    logic [1:0]           r_pcnt;
    logic [MAX_NODES-1:0] r_del, r_vis, r_side;
    logic [KEY_W-1:0]     r_best, r_c, r_best_cut;
    logic [WM_W-1:0]      r_a1, r_sum;

    logic [IDX_W-1:0]     idx;
    logic                 in_fire, out_fire, load_out;
    logic                 w_we, k_we, g_we;
    logic [ADDR_W-1:0]    w_waddr, w_raddr;
    logic [WM_W-1:0]      w_wdata;
    logic [IDX_W-1:0]     k_waddr, g_waddr, g_raddr, g_wdata;
    logic [KEY_W-1:0]     k_wdata;
    logic [KEY_W:0]       key_sum;
    logic [WM_W:0]        mrg_sum;
    logic [WM_W-1:0]      mrg_sat;

    assign idx      = r_idx[IDX_W-1:0];
    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;
    assign load_out = (i_cmd.op == OP_OUT) && i_cmd.idx_inc;
    assign i_in.ready  = (i_cmd.op == OP_IDLE);
    assign i_cfg.ready = 1'b1;

    assign key_sum = {1'b0, r_rk} + (KEY_W+1)'(r_rw);
    assign mrg_sum = {1'b0, r_a1} + {1'b0, r_rw};
    assign mrg_sat = mrg_sum[WM_W] ? '1 : mrg_sum[WM_W-1:0];

    always_comb begin
        priority if (r_cfg < CFG_W'(2)) n_clamp = CNT_W'(2);
        else if (CNT_W'(r_cfg) > CNT_W'(MAX_NODES)) n_clamp = CNT_W'(MAX_NODES);
        else n_clamp = CNT_W'(r_cfg);
    end

    always_comb begin
        o_st.load_last = in_fire && i_in.last_entry;
        o_st.idx_end   = (r_idx == r_n);
        o_st.skip      = r_del[idx] || (idx == r_s0) || (idx == r_s1);
        o_st.live_one  = (r_live <= CNT_W'(1));
        o_st.live_two  = (r_live == CNT_W'(2));
        o_st.iter_done = (r_iter == r_live);
        o_st.out_space = !r_ov || o_out.ready;
        o_st.improved  = r_imp;
        o_st.n         = r_n;
    end

    // weight matrix ports
    always_comb begin
        w_we    = 1'b0;
        w_waddr = {i_in.row, i_in.col};
        w_wdata = WM_W'(i_in.weight);
        unique case (i_cmd.op)
            OP_IDLE:  w_we = in_fire;
            OP_M_WR1: begin
                w_we    = 1'b1;
                w_waddr = {r_s0, idx};
                w_wdata = mrg_sat;
            end
            OP_M_WR2: begin
                w_we    = 1'b1;
                w_waddr = {idx, r_s0};
                w_wdata = r_sum;
            end
            default: w_we = 1'b0;
        endcase
        unique case (i_cmd.op)
            OP_PAIR_RD: w_raddr = {r_a, r_b};
            OP_UPD:     w_raddr = {idx, r_s1};
            OP_M_RD1:   w_raddr = {r_s0, idx};
            OP_M_RD2:   w_raddr = {idx, r_s1};
            default:    w_raddr = {idx, r_s1};
        endcase
    end

    // key and group label ports
    always_comb begin
        k_we    = 1'b0;
        k_waddr = idx;
        k_wdata = '0;
        g_we    = 1'b0;
        g_waddr = idx;
        g_wdata = idx;
        g_raddr = idx;
        unique case (i_cmd.op)
            OP_KCLR:  k_we = i_cmd.idx_inc;
            OP_UPD: begin
                k_we    = r_pend && r_elig;
                k_waddr = r_idx_d;
                k_wdata = key_sum[KEY_W] ? '1 : key_sum[KEY_W-1:0];
            end
            OP_GINIT: g_we = i_cmd.idx_inc;
            OP_RELAB: begin
                g_we    = r_pend && (r_rg == r_gt);
                g_waddr = r_idx_d;
                g_wdata = r_gs;
            end
            OP_G_RDT: g_raddr = r_s1;
            OP_G_RDS: g_raddr = r_s0;
            default:  k_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_wmem[w_waddr] <= w_wdata;
        end
        r_rw <= r_wmem[w_raddr];
        if (k_we) begin
            r_kmem[k_waddr] <= k_wdata;
        end
        r_rk <= r_kmem[idx];
        if (g_we) begin
            r_gmem[g_waddr] <= g_wdata;
        end
        r_rg <= r_gmem[g_raddr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= NODE_COUNT_RST;
            r_n        <= CNT_W'(MAX_NODES);
            r_idx      <= '0;
            r_pend     <= 1'b0;
            r_ov       <= 1'b0;
            r_del      <= '0;
            r_vis      <= '0;
            r_side     <= '0;
            r_live     <= '0;
            r_iter     <= '0;
            r_imp      <= 1'b0;
            r_pcnt     <= '0;
            r_best_cut <= '1;
        end else begin
            if (i_cfg.valid) begin
                r_cfg <= i_cfg.data;
            end
            r_pend <= i_cmd.idx_inc;
            priority if (i_cmd.idx_clr) r_idx <= '0;
            else if (i_cmd.idx_inc)     r_idx <= r_idx + 1'b1;
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (out_fire) begin
                r_ov <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_INIT: begin
                    r_n        <= n_clamp;
                    r_live     <= n_clamp;
                    r_del      <= '0;
                    r_side     <= '0;
                    r_best_cut <= '1;
                end
                OP_PH_START: begin
                    r_iter <= '0;
                    r_pcnt <= '0;
                end
                OP_PAIR: begin
                    if (i_cmd.idx_inc && !r_del[idx] && r_pcnt != 2'd2) begin
                        r_pcnt <= r_pcnt + 1'b1;
                    end
                end
                OP_KCLR:     r_vis <= '0;
                OP_PICK_END: begin
                    r_vis[r_v] <= 1'b1;
                    r_iter     <= r_iter + 1'b1;
                end
                OP_CMP: begin
                    r_imp <= (r_c < r_best_cut);
                    if (r_c < r_best_cut) begin
                        r_best_cut <= r_c;
                    end
                end
                OP_SIDE: begin
                    if (r_pend) begin
                        r_side[r_idx_d] <= (r_rg == r_gt);
                    end
                end
                OP_DEL: begin
                    r_del[r_s1] <= 1'b1;
                    r_live      <= r_live - 1'b1;
                end
                default: r_imp <= r_imp;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx_d <= idx;
        r_elig  <= !r_del[idx] && !r_vis[idx];
        // running maximum of the pick scan, ties go to the later index
        if (i_cmd.op == OP_PICK) begin
            if (r_pend && r_elig && (r_best <= r_rk)) begin
                r_best <= r_rk;
                r_v    <= r_idx_d;
            end
        end else if (i_cmd.op != OP_PICK_END) begin
            r_best <= '0;
            r_v    <= '0;
        end
        unique case (i_cmd.op)
            OP_PAIR: begin
                if (i_cmd.idx_inc && !r_del[idx]) begin
                    if (r_pcnt == 2'd0) r_a <= idx;
                    if (r_pcnt == 2'd1) r_b <= idx;
                end
            end
            OP_PAIR_WT: begin
                r_c  <= KEY_W'(r_rw);
                r_s0 <= r_a;
                r_s1 <= r_b;
            end
            OP_PICK_END: begin
                r_s0 <= r_s1;
                r_s1 <= r_v;
                r_c  <= r_best;
            end
            OP_G_RDS: r_gt  <= r_rg;
            OP_G_LAT: r_gs  <= r_rg;
            OP_M_RD2: r_a1  <= r_rw;
            OP_M_WR1: r_sum <= mrg_sat;
            default:  r_a1  <= r_a1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_out.node        <= idx;
            o_out.in_cut_side <= r_side[idx];
            o_out.cut_value   <= r_best_cut;
            o_out.last_node   <= (r_idx == r_n - 1'b1);
        end
    end

    assign o_out.valid = r_ov;
endmodule

// ----- sv/global_min_cut_engine_core.sv -----
// top level of the global minimum cut engine: controller plus datapath
//
// usage: load the weight matrix one entry per input transaction (row, col,
// weight); entries are taken one per cycle while the engine is idle. the
// transaction with last_entry set stores its entry and starts the search over
// node_count nodes (written beforehand on the configuration channel, 2..64).
// every entry used by the search must be rewritten before each search, since
// the merges overwrite the matrix in place.
// search: each phase with more than two live vertices runs a key clear and,
// per added vertex, a pick scan and a key update over n slots; a phase with
// two live vertices scans for the remaining pair instead; every phase then
// merges the last two vertices in the weight memory.
// results: n output transactions, node 0 first, one per cycle when the sink
// is ready; a stalled sink holds the output register and pauses the engine.
// the next load may begin while the final result still waits to be taken.
// reset: node_count returns to 64, the output channel is emptied and the
// engine idles; the weight matrix is not cleared.
`timescale 1ns / 1ps
module global_min_cut_engine_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gmc_in_if.sink    i_in,
    gmc_out_if.source o_out,
    gmc_cfg_if.sink   i_cfg
);
    import gmc_pkg::*;

    t_cmd  cmd;
    t_stat st;
    logic [IDX_W-1:0] last_idx;

    gmc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    gmc_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_st    (st),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg)
    );

    assign last_idx = IDX_W'(st.n - 1'b1);

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && i_in.last_entry |=> !i_in.ready)
        else $error("engine accepted input right after starting a search");

    a_last_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.last_node |-> o_out.node == last_idx)
        else $error("last_node flagged on a node other than the final one");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.idx_inc |-> !st.idx_end)
        else $error("sweep index advanced past the node count");
endmodule

// ----- verif/gmc_checker.sv -----
// checker: watches the min cut engine channels, predicts per-node results and compares
`timescale 1ns / 1ps
module gmc_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gmc_in_if         i_in,
    gmc_out_if        o_out,
    gmc_cfg_if        i_cfg,
    output int        o_fail_cnt,
    output int        o_pending,
    output int        o_result_cnt
);
    import gmc_pkg::*;

    typedef struct {
        logic [IDX_W-1:0] node;
        logic             side;
        logic [KEY_W-1:0] cut;
        logic             last;
    } t_node_res;

    localparam logic [KEY_W-1:0] KEY_MAX = '1;
    localparam logic [WM_W-1:0]  WM_MAX  = '1;

    logic [WM_W-1:0] wmat [MAX_NODES][MAX_NODES];
    int unsigned     nodes_cfg;
    t_node_res       cut_results_q [$];

    function automatic logic [KEY_W-1:0] key_add(logic [KEY_W-1:0] a, logic [WM_W-1:0] b);
        logic [KEY_W:0] s;
        s = {1'b0, a} + b;
        return s[KEY_W] ? KEY_MAX : s[KEY_W-1:0];
    endfunction

    task automatic predict_min_cut();
        int unsigned     n, live, j, s, t, v, i, u, gt, gs;
        logic            gone [MAX_NODES];
        logic            seen [MAX_NODES];
        logic            side [MAX_NODES];
        int unsigned     grp  [MAX_NODES];
        logic [KEY_W-1:0] key [MAX_NODES];
        logic [KEY_W-1:0] best, c, bk;
        logic [WM_W:0]   sum;
        t_node_res       r;
        n = nodes_cfg < 2 ? 2 : (nodes_cfg > MAX_NODES ? MAX_NODES : nodes_cfg);
        for (i = 0; i < MAX_NODES; i++) begin
            gone[i] = 0; side[i] = 0; grp[i] = i;
        end
        best = KEY_MAX;
        for (live = n; live > 1; live--) begin
            s = 0; t = 0;
            if (live == 2) begin
                j = 0;
                for (i = 0; i < n; i++)
                    if (!gone[i] && j < 2) begin
                        if (j == 0) s = i; else t = i;
                        j++;
                    end
                c = KEY_W'(wmat[s][t]);
            end else begin
                for (i = 0; i < MAX_NODES; i++) begin
                    key[i] = '0; seen[i] = 0;
                end
                for (j = 1; j <= live; j++) begin
                    // highest index wins ties
                    v = 0; bk = '0;
                    for (i = 0; i < n; i++)
                        if (!gone[i] && !seen[i] && bk <= key[i]) begin
                            v = i; bk = key[i];
                        end
                    seen[v] = 1;
                    for (u = 0; u < n; u++)
                        if (!gone[u] && !seen[u]) key[u] = key_add(key[u], wmat[u][v]);
                    if (j + 1 == live) s = v;
                    if (j == live) t = v;
                end
                c = key[t];
            end
            if (c < best) begin
                best = c;
                for (i = 0; i < n; i++) side[i] = (grp[i] == grp[t]);
            end
            gt = grp[t]; gs = grp[s];
            for (v = 0; v < n; v++)
                if (!gone[v] && v != s && v != t) begin
                    sum = {1'b0, wmat[s][v]} + wmat[v][t];
                    wmat[s][v] = sum[WM_W] ? WM_MAX : sum[WM_W-1:0];
                    wmat[v][s] = wmat[s][v];
                end
            gone[t] = 1;
            for (v = 0; v < n; v++) if (grp[v] == gt) grp[v] = gs;
        end
        for (i = 0; i < n; i++) begin
            r.node = IDX_W'(i); r.side = side[i]; r.cut = best; r.last = (i + 1 == n);
            cut_results_q.insert(cut_results_q.size(), r);
        end
    endtask

    always @(posedge i_clk) begin
        t_node_res e;
        if (!i_rst_n) begin
            nodes_cfg = MAX_NODES;
            cut_results_q.delete();
            o_fail_cnt <= 0;
            o_result_cnt <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) nodes_cfg = i_cfg.data;
            if (i_in.valid && i_in.ready) begin
                wmat[i_in.row][i_in.col] = WM_W'(i_in.weight);
                if (i_in.last_entry) predict_min_cut();
            end
            if (o_out.valid && o_out.ready) begin
                o_result_cnt <= o_result_cnt + 1;
                if (cut_results_q.size() == 0) begin
                    $display("%0t: unexpected result transaction node=%0d", $time, o_out.node);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    e = cut_results_q.pop_front();
                    if (o_out.node !== e.node || o_out.in_cut_side !== e.side ||
                        o_out.cut_value !== e.cut || o_out.last_node !== e.last) begin
                        $display("%0t: mismatch exp node=%0d side=%0d cut=%h last=%0d",
                                 $time, e.node, e.side, e.cut, e.last);
                        $display("%0t:          act node=%0d side=%0d cut=%h last=%0d",
                                 $time, o_out.node, o_out.in_cut_side, o_out.cut_value,
                                 o_out.last_node);
                        o_fail_cnt <= o_fail_cnt + 1;
                    end
                end
            end
            o_pending <= cut_results_q.size();
        end
    end
endmodule

// ----- verif/tb_global_min_cut_engine_core.sv -----
// testbench top: drives matrix loads and node count writes, stalls the result side
`timescale 1ns / 1ps
module tb_global_min_cut_engine_core;
    import gmc_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   fail_cnt, pending, result_cnt;
    int   cycle_cnt = 0;
    int   loads_done = 0;
    logic long_stall = 0;
    int   entries_sent = 0;

    gmc_in_if  in_ch();
    gmc_out_if out_ch();
    gmc_cfg_if cfg_ch();

    global_min_cut_engine_core u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    gmc_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg       (cfg_ch),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (pending),
        .o_result_cnt(result_cnt)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 3000000) begin
            $display("global_min_cut_engine_core test failed");
            $finish;
        end
    end

    // receiver stall pattern, with a long hold-off on request
    initial begin
        out_ch.ready = 0;
        forever begin
            @(negedge i_clk);
            if (long_stall) out_ch.ready <= 0;
            else if (($urandom % 64) < 20) out_ch.ready <= ($urandom % 4) == 0;
            else out_ch.ready <= 1;
        end
    end

    task automatic send_entry(input int r, input int c, input logic [WEIGHT_BITS-1:0] w,
                              input logic last);
        in_ch.valid      <= 1;
        in_ch.row        <= IDX_W'(r);
        in_ch.col        <= IDX_W'(c);
        in_ch.weight     <= w;
        in_ch.last_entry <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        entries_sent++;
        @(negedge i_clk);
        // bursts with random gaps
        if (($urandom % 8) == 0) begin
            in_ch.valid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    task automatic write_nodes(input int n);
        cfg_ch.valid <= 1;
        cfg_ch.data  <= CFG_W'(n);
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 0;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // full symmetric load; mode picks the weight shape
    task automatic load_graph(input int n, input int mode);
        logic [WEIGHT_BITS-1:0] w;
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++) begin
                case (mode)
                    0: w = '0;
                    1: w = '1;
                    2: w = (r == c) ? '0 : WEIGHT_BITS'($urandom_range(0, 8));
                    default: w = (($urandom % 3) == 0) ? '0 : WEIGHT_BITS'($urandom);
                endcase
                if (c < r) continue;
                send_entry(r, c, w, 0);
                if (r != c) send_entry(c, r, w, 0);
            end
        // trailing entry repeats an in-range cell, or lands beyond the node count
        if (mode == 3) send_entry(63, 63, '1, 1);
        else send_entry(0, 0, '0, 1);
        loads_done++;
    endtask

    initial begin
        in_ch.valid = 0; in_ch.row = '0; in_ch.col = '0; in_ch.weight = '0;
        in_ch.last_entry = 0;
        cfg_ch.valid = 0; cfg_ch.data = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: smallest graph, zero and full-scale weights, below-range count
        write_nodes(2);
        load_graph(2, 0); wait_drained();
        load_graph(2, 1); wait_drained();
        write_nodes(0);
        load_graph(2, 3); wait_drained();
        write_nodes(3);
        load_graph(3, 1); wait_drained();

        // long receiver hold-off while loads continue
        write_nodes(4);
        long_stall <= 1;
        fork
            begin load_graph(4, 2); load_graph(4, 3); end
            begin repeat (400) @(negedge i_clk); long_stall <= 0; end
        join
        wait_drained();

        // random part: small graphs of random size and weight shape
        while (entries_sent < 95) begin
            int n;
            n = $urandom_range(2, 5);
            write_nodes(n);
            load_graph(n, $urandom_range(0, 9) < 2 ? 2 : 3);
            wait_drained();
        end

        $display("ran %0d searches over %0d entry transactions, %0d results checked",
                 loads_done, entries_sent, result_cnt);
        if (fail_cnt == 0) $display("global_min_cut_engine_core test passed");
        else $display("global_min_cut_engine_core test failed");
        $finish;
    end
endmodule
